FILE: rtl/assert_macros.svh
// Assertion macros for the checker file pnt_check.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising clock edge, skip while reset is asserted.
`define PNT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Check prop on every rising clock edge, reset included.
`define PNT_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("assertion failed");

`endif

FILE: rtl/pnt_pkg.sv
package pnt_pkg;

	localparam int DSUM_W = 34;

	typedef logic [DSUM_W-1:0] dsum_t;

	localparam dsum_t DSUM_MAX = '1;

endpackage

FILE: rtl/pnt_in_if.sv
interface pnt_in_if #(
	parameter int NUMBER_WIDTH = 31
) ();

	logic                    valid;
	logic                    ready;
	logic [NUMBER_WIDTH-1:0] n;

	modport source (output valid, output n, input ready);
	modport sink (input valid, input n, output ready);

endinterface

FILE: rtl/pnt_out_if.sv
interface pnt_out_if import pnt_pkg::*; ();

	logic  valid;
	logic  ready;
	dsum_t divisor_sum;
	logic  is_perfect;

	modport source (output valid, output divisor_sum, output is_perfect, input ready);
	modport sink (input valid, input divisor_sum, input is_perfect, output ready);

endinterface

FILE: rtl/pnt_div.sv
module pnt_div #(
	parameter int W = 31
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);

	localparam int CNT_W = $clog2(W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [W:0]       rem_sh;
	logic [W:0]       rem_nx;
	logic             ge;

	assign rem_sh = {rem_q, quo_q[W-1]};
	assign ge     = rem_sh >= {1'b0, divisor};
	assign rem_nx = ge ? rem_sh - {1'b0, divisor} : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_nx[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

FILE: rtl/perfect_number_test_core.sv
// Sequence: n below 2 goes straight to the finish state; otherwise each divisor d up to
// sqrt(n) is tried by the one-bit-per-cycle remainder unit; proper divisors d, n/d are summed.
// Throughput: one word at a time; the next word is taken the cycle after the
// result is registered, while that result may still wait on the output.
// Reset: arst_n clears the sequencer to idle and drops result valid.
module perfect_number_test_core import pnt_pkg::*; #(
	parameter int NUMBER_WIDTH = 31
) (
	input logic        clk,
	input logic        arst_n,
	pnt_in_if.sink     number,
	pnt_out_if.source  result
);

	localparam int W     = NUMBER_WIDTH;
	localparam int SUM_W = NUMBER_WIDTH + 4;
	localparam int EXT_W = (SUM_W > DSUM_W) ? SUM_W : DSUM_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_ADD_D,
		S_ADD_Q,
		S_FIN
	} state_t;

	state_t           state_q;
	logic             start_q;
	logic             out_valid_q;
	dsum_t            out_sum_q;
	logic             out_perf_q;
	logic [W-1:0]     n_q;
	logic [W-1:0]     d_q;
	logic [SUM_W-1:0] sum_q;

	logic             div_done;
	logic [W-1:0]     quo;
	logic [W-1:0]     rem;
	logic [W-1:0]     addend;
	logic [SUM_W-1:0] add_res;
	logic [EXT_W-1:0] sum_ext;
	dsum_t            sum_sat;
	logic             n_small;
	logic             fin_fire;
	logic             start_nx;

	pnt_div #(.W(W)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start_q),
		.dividend  (n_q),
		.divisor   (d_q),
		.done      (div_done),
		.quotient  (quo),
		.remainder (rem)
	);

	assign addend   = (state_q == S_ADD_D) ? d_q : quo;
	assign add_res  = sum_q + SUM_W'(addend);
	assign sum_ext  = EXT_W'(sum_q);
	assign sum_sat  = (sum_ext > EXT_W'(DSUM_MAX)) ? DSUM_MAX : sum_ext[DSUM_W-1:0];
	assign n_small  = number.n < W'(2);
	assign fin_fire = (state_q == S_FIN) && (!out_valid_q || result.ready);
	assign start_nx = ((state_q == S_IDLE) && number.valid && !n_small) ||
		((state_q == S_DIV) && div_done && (quo >= d_q) && (rem != '0)) ||
		(state_q == S_ADD_Q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q     <= start_nx;
			out_valid_q <= fin_fire || (out_valid_q && !result.ready);
			unique case (state_q)
				S_IDLE: begin
					if (number.valid) begin
						if (n_small) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						priority if (quo < d_q) begin
							state_q <= S_FIN;
						end else if (rem == '0) begin
							state_q <= S_ADD_D;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_ADD_D: begin
					state_q <= S_ADD_Q;
				end
				S_ADD_Q: begin
					state_q <= S_DIV;
				end
				S_FIN: begin
					if (fin_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (number.valid) begin
					n_q   <= number.n;
					d_q   <= W'(1);
					sum_q <= '0;
				end
			end
			S_DIV: begin
				if (div_done && quo >= d_q && rem != '0) begin
					d_q <= d_q + W'(1);
				end
			end
			S_ADD_D: begin
				if (d_q < n_q) begin
					sum_q <= add_res;
				end
			end
			S_ADD_Q: begin
				if (quo != d_q && quo < n_q) begin
					sum_q <= add_res;
				end
				d_q <= d_q + W'(1);
			end
			S_FIN: begin
				if (fin_fire) begin
					out_sum_q  <= sum_sat;
					out_perf_q <= (n_q != '0) && (sum_q == SUM_W'(n_q));
				end
			end
			default: begin
			end
		endcase
	end

	assign number.ready       = (state_q == S_IDLE);
	assign result.valid       = out_valid_q;
	assign result.divisor_sum = out_sum_q;
	assign result.is_perfect  = out_perf_q;

endmodule

FILE: rtl/pnt_check.sv
`include "assert_macros.svh"

module pnt_check import pnt_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  in_valid,
	input logic  in_ready,
	input logic  out_valid,
	input logic  out_ready,
	input dsum_t out_sum,
	input logic  out_perf
);

	`PNT_ASSERT(a_busy_after_accept, clk, arst_n, (in_valid && in_ready) |=> !in_ready)

	`PNT_ASSERT(a_result_after_work, clk, arst_n, $rose(out_valid) |-> $past(!in_ready))

	`PNT_ASSERT(a_result_holds, clk, arst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_sum) && $stable(out_perf)))

	`PNT_ASSERT_ALWAYS(a_reset_no_result, clk, !arst_n |=> !out_valid)

endmodule

bind perfect_number_test_core pnt_check u_pnt_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (number.valid),
	.in_ready  (number.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_sum   (result.divisor_sum),
	.out_perf  (result.is_perfect)
);
